FILE: src/tile_background_pixel_fetch_defines.svh
// ---------------------------------------------------------------------------
// Tile background pixel fetch: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBPF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBPF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tbpf_pkg.sv
// ---------------------------------------------------------------------------
// tbpf_pkg
// Types and fixed constants of the tile background pixel fetch block.
// ---------------------------------------------------------------------------
`default_nettype none

package tbpf_pkg;

    localparam int VRAM_BYTES   = 8192;
    localparam int VRAM_ADDR_W  = 13;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] SCREEN_LINES = 8'd144;

    // Both tile maps sit in the top quarter of video memory (0x1800 and 0x1C00).
    localparam logic [1:0] MAP_REGION = 2'b11;

    // Input word kinds.
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SELECT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_DATA_SELECT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_PALETTE       = 3'd4;

    // Per-pixel context carried alongside the tile map read.
    typedef struct packed {
        logic [2:0] col;
        logic [2:0] row;
        logic [7:0] x;
        logic [7:0] y;
    } t_pix;

endpackage

`default_nettype wire

FILE: src/tbpf_ram.sv
// ---------------------------------------------------------------------------
// tbpf_ram
// Generic synchronous RAM: one write port and two read ports with
// registered read data. A read at the address being written returns the
// old contents. Read data holds while its read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re_a,
    input  wire logic [AddrW-1:0] i_raddr_a,
    output logic      [WIDTH-1:0] o_rdata_a,
    input  wire logic             i_re_b,
    input  wire logic [AddrW-1:0] i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/tile_background_pixel_fetch.sv
// ---------------------------------------------------------------------------
// tile_background_pixel_fetch
// Background tile pixel fetch, 2 bits per pixel, with 8 KiB video memory.
//
// The input channel (i_in_valid / o_in_stall) carries one word per item:
// either a video memory byte write or a request to render one pixel. The
// output channel (o_out_valid / i_out_stall) returns the shade, column and
// line of each rendered pixel that lies on the screen; writes and
// off-screen pixels produce no output word.
// Throughput is one input word per clock while the output is not stalled.
// A render word passes through the tile map read at its accepting edge,
// then the tile row read of both planes, and then the palette lookup,
// which fills the output register.
// Video memory is split into an even and an odd byte bank so that the two
// bit planes of a tile row are read in the same cycle.
// When the receiver stalls a valid output, the whole pipeline freezes and
// the input is stalled in the same cycle. Reset clears the pipeline and
// the configuration registers; video memory is not cleared and must be
// written before it is used for rendering.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tile_background_pixel_fetch_defines.svh"

module tile_background_pixel_fetch
    import tbpf_pkg::*;
#(
    parameter int SCREEN_WIDTH = 160
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_mode,
    input  wire logic [VRAM_ADDR_W-1:0] i_vram_addr,
    input  wire logic [7:0]             i_vram_data,
    input  wire logic [7:0]             i_pixel_x,
    input  wire logic [7:0]             i_line_y,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic      [1:0]             o_shade,
    output logic      [7:0]             o_out_x,
    output logic      [7:0]             o_out_y
);

    localparam int BANK_DEPTH = VRAM_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [8:0] PIX_LIMIT = 9'(SCREEN_WIDTH);

    // Configuration registers.
    logic [7:0] r_scroll_x;
    logic [7:0] r_scroll_y;
    logic       r_map_select;
    logic       r_tile_data_select;
    logic [7:0] r_bg_palette;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x         <= '0;
            r_scroll_y         <= '0;
            r_map_select       <= 1'b0;
            r_tile_data_select <= 1'b0;
            r_bg_palette       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCROLL_X:         r_scroll_x         <= i_cfg_data;
                REG_SCROLL_Y:         r_scroll_y         <= i_cfg_data;
                REG_MAP_SELECT:       r_map_select       <= i_cfg_data[0];
                REG_TILE_DATA_SELECT: r_tile_data_select <= i_cfg_data[0];
                REG_BG_PALETTE:       r_bg_palette       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline registers.
    logic       r_s1_valid;
    t_pix       r_s1;
    logic       r_s1_odd;
    logic       r_s2_valid;
    logic [2:0] r_s2_col;
    logic [7:0] r_s2_x;
    logic [7:0] r_s2_y;
    logic       r_out_valid;
    logic [1:0] r_out_shade;
    logic [7:0] r_out_x;
    logic [7:0] r_out_y;

    logic advance;
    logic in_acc;
    logic vram_wr;
    logic on_screen;
    logic start_render;
    logic [7:0] bg_x;
    logic [7:0] bg_y;
    logic [VRAM_ADDR_W-1:0] map_addr;
    t_pix n_s1;

    logic [7:0] even_a;
    logic [7:0] odd_a;
    logic [7:0] even_b;
    logic [7:0] odd_b;
    logic [7:0] tile;
    logic [BANK_AW-1:0] tile_word;
    logic [2:0] bit_sel;
    logic [1:0] colour;
    logic [1:0] n_shade;

    // The pipeline moves unless a finished word is held by the receiver.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;
    assign in_acc     = i_in_valid && advance;
    assign vram_wr    = in_acc && (i_mode == MODE_WRITE);

    assign on_screen    = (i_line_y < SCREEN_LINES) && ({1'b0, i_pixel_x} < PIX_LIMIT);
    assign start_render = in_acc && (i_mode == MODE_RENDER) && on_screen;

    assign bg_x     = i_pixel_x + r_scroll_x;
    assign bg_y     = i_line_y + r_scroll_y;
    assign map_addr = {MAP_REGION, r_map_select, bg_y[7:3], bg_x[7:3]};

    always_comb begin
        n_s1.col = bg_x[2:0];
        n_s1.row = bg_y[2:0];
        n_s1.x   = i_pixel_x;
        n_s1.y   = i_line_y;
    end

    // Port A of each bank serves the tile map read, port B the tile row.
    // Writes land in the same cycle they are accepted; a tile row read that
    // coincides with a later write sees the older byte, as ordering requires.
    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (vram_wr && !i_vram_addr[0]),
        .i_waddr   (i_vram_addr[VRAM_ADDR_W-1:1]),
        .i_wdata   (i_vram_data),
        .i_re_a    (advance),
        .i_raddr_a (map_addr[VRAM_ADDR_W-1:1]),
        .o_rdata_a (even_a),
        .i_re_b    (advance),
        .i_raddr_b (tile_word),
        .o_rdata_b (even_b)
    );

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (vram_wr && i_vram_addr[0]),
        .i_waddr   (i_vram_addr[VRAM_ADDR_W-1:1]),
        .i_wdata   (i_vram_data),
        .i_re_a    (advance),
        .i_raddr_a (map_addr[VRAM_ADDR_W-1:1]),
        .o_rdata_a (odd_a),
        .i_re_b    (advance),
        .i_raddr_b (tile_word),
        .o_rdata_b (odd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= start_render;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Tile rows start on even addresses, so the low plane is in the even
    // bank and the high plane in the odd bank at the same word index.
    // Signed mode maps tile 0..127 to 0x1000 and 128..255 to 0x0800, which
    // only sets address bit 12 for the lower half of tile numbers.
    assign tile      = r_s1_odd ? odd_a : even_a;
    assign tile_word = {!r_tile_data_select && !tile[7], tile, r_s1.row};

    assign bit_sel = ~r_s2_col;
    assign colour  = {odd_b[bit_sel], even_b[bit_sel]};

    always_comb begin
        case (colour)
            2'd0:    n_shade = r_bg_palette[1:0];
            2'd1:    n_shade = r_bg_palette[3:2];
            2'd2:    n_shade = r_bg_palette[5:4];
            2'd3:    n_shade = r_bg_palette[7:6];
            default: n_shade = r_bg_palette[1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1        <= n_s1;
            r_s1_odd    <= map_addr[0];
            r_s2_col    <= r_s1.col;
            r_s2_x      <= r_s1.x;
            r_s2_y      <= r_s1.y;
            r_out_shade <= n_shade;
            r_out_x     <= r_s2_x;
            r_out_y     <= r_s2_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_shade     = r_out_shade;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

    `TBPF_ASSERT_NEXT(a_write_no_render, i_clk, i_rst_n,
        vram_wr, !r_s1_valid,
        "write word entered the render pipeline")
    `TBPF_ASSERT_NEXT(a_offscreen_dropped, i_clk, i_rst_n,
        in_acc && (i_line_y >= SCREEN_LINES), !r_s1_valid,
        "off-screen line entered the render pipeline")
    `TBPF_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n,
        r_out_valid && i_out_stall,
        $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_out_shade),
        "pipeline moved while output was stalled")
    `TBPF_ASSERT_NEXT(a_s2_to_out, i_clk, i_rst_n,
        r_s2_valid && advance, r_out_valid,
        "pixel lost between tile row read and output")

endmodule

`default_nettype wire

FILE: sim/tb_tile_background_pixel_fetch.sv
// ---------------------------------------------------------------------------
// tb_tile_background_pixel_fetch
// Self-checking bench for the background tile pixel fetch block.
// The bench keeps its own image of video memory and of the configuration
// registers and predicts the shade of every on-screen render word at the
// moment it is accepted. Results are checked in order as they leave the
// block. Both channels idle and stall at random, with one steady stretch,
// one long output hold-off and several register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_tile_background_pixel_fetch;
    import tbpf_pkg::*;

    localparam int SCREEN_WIDTH = 160;
    localparam int PIPE_SETTLE  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1100;
    localparam int IDLE_PERCENT = 28;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_BASE     = 13'h1800;
    localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_BASE    = 13'h1C00;
    localparam logic [VRAM_ADDR_W-1:0] SIGNED_TILE_BASE = 13'h1000;
    localparam int                     MAP_SPAN         = 2048;

    typedef struct packed {
        logic [1:0] shade;
        logic [7:0] x;
        logic [7:0] y;
    } t_pixel;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_mode;
    logic [VRAM_ADDR_W-1:0] i_vram_addr;
    logic [7:0]             i_vram_data;
    logic [7:0]             i_pixel_x;
    logic [7:0]             i_line_y;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_shade;
    logic [7:0]             o_out_x;
    logic [7:0]             o_out_y;

    // Shadow of the block's state.
    logic [7:0] vram_image   [VRAM_BYTES];
    bit         vram_written [VRAM_BYTES];
    logic [7:0] scroll_x_q      = '0;
    logic [7:0] scroll_y_q      = '0;
    logic       map_sel_q       = 1'b0;
    logic       tile_unsigned_q = 1'b0;
    logic [7:0] palette_q       = '0;

    t_pixel pending_pixels [$];
    t_pixel expected_pixel;
    int     words_sent      = 0;
    int     mismatches      = 0;
    int     cycle_count     = 0;
    int     out_hold_cycles = 0;
    bit     steady_flow     = 1'b0;

    tile_background_pixel_fetch #(
        .SCREEN_WIDTH(SCREEN_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_vram_addr (i_vram_addr),
        .i_vram_data (i_vram_data),
        .i_pixel_x   (i_pixel_x),
        .i_line_y    (i_line_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_shade     (o_shade),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pixel prediction
    // ------------------------------------------------------------------
    function automatic bit on_screen(logic [7:0] x, logic [7:0] y);
        return (x < SCREEN_WIDTH) && (y < SCREEN_LINES);
    endfunction

    function automatic logic [VRAM_ADDR_W-1:0] map_entry_addr(logic [7:0] x, logic [7:0] y);
        logic [7:0] bg_x;
        logic [7:0] bg_y;
        bg_x = x + scroll_x_q;
        bg_y = y + scroll_y_q;
        return (map_sel_q ? MAP_HIGH_BASE : MAP_LOW_BASE) + {bg_y[7:3], 5'b0} + bg_x[7:3];
    endfunction

    function automatic logic [VRAM_ADDR_W-1:0] tile_row_addr(logic [7:0] tile, logic [7:0] y);
        logic [7:0]             bg_y;
        logic [VRAM_ADDR_W-1:0] base;
        bg_y = y + scroll_y_q;
        if (tile_unsigned_q) begin
            base = {1'b0, tile, 4'b0};
        end else begin
            // Tile number is sign-extended, times 16, around the signed base.
            base = SIGNED_TILE_BASE + {tile[7], tile, 4'b0};
        end
        return base + {bg_y[2:0], 1'b0};
    endfunction

    function automatic t_pixel predict_pixel(logic [7:0] x, logic [7:0] y);
        logic [7:0]             bg_x;
        logic [7:0]             plane_lo;
        logic [7:0]             plane_hi;
        logic [VRAM_ADDR_W-1:0] row;
        logic [2:0]             bitpos;
        logic [1:0]             color;
        t_pixel                 pix;
        bg_x     = x + scroll_x_q;
        row      = tile_row_addr(vram_image[map_entry_addr(x, y)], y);
        plane_lo = vram_image[row];
        plane_hi = vram_image[row + 1'b1];
        // Bit 7 of each plane byte is the leftmost pixel of the tile.
        bitpos    = 3'd7 - bg_x[2:0];
        color     = {plane_hi[bitpos], plane_lo[bitpos]};
        pix.shade = palette_q[{color, 1'b0} +: 2];
        pix.x     = x;
        pix.y     = y;
        return pix;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_word(input logic mode, input logic [VRAM_ADDR_W-1:0] addr,
                             input logic [7:0] data, input logic [7:0] x,
                             input logic [7:0] y);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_vram_addr <= addr;
        i_vram_data <= data;
        i_pixel_x   <= x;
        i_line_y    <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        if (mode == MODE_WRITE) begin
            vram_image[addr]   = data;
            vram_written[addr] = 1'b1;
        end else if (on_screen(x, y)) begin
            pending_pixels.push_back(predict_pixel(x, y));
        end
    endtask

    task automatic write_byte(input logic [VRAM_ADDR_W-1:0] addr, input logic [7:0] data);
        send_word(MODE_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    // An on-screen pixel first gets any map entry or plane byte it reads
    // written, so that no render ever touches uninitialized memory.
    task automatic render_pixel(input logic [7:0] x, input logic [7:0] y);
        logic [VRAM_ADDR_W-1:0] entry;
        logic [VRAM_ADDR_W-1:0] row;
        if (on_screen(x, y)) begin
            entry = map_entry_addr(x, y);
            if (!vram_written[entry]) write_byte(entry, 8'($urandom));
            row = tile_row_addr(vram_image[entry], y);
            if (!vram_written[row]) write_byte(row, 8'($urandom));
            if (!vram_written[row + 1'b1]) write_byte(row + 1'b1, 8'($urandom));
        end
        send_word(MODE_RENDER, 13'($urandom), 8'($urandom), x, y);
    endtask

    task automatic render_run(input int x0, input logic [7:0] y, input int len);
        for (int k = 0; k < len && x0 + k < 256; k++) begin
            render_pixel(8'(x0 + k), y);
        end
    endtask

    // Writes both plane bytes of a tile row, then the map entry, then renders
    // right behind them and overwrites the map entry right behind the render.
    task automatic rewrite_and_render(input logic [7:0] x, input logic [7:0] y);
        logic [7:0]             tile;
        logic [VRAM_ADDR_W-1:0] entry;
        logic [VRAM_ADDR_W-1:0] row;
        tile  = 8'($urandom);
        entry = map_entry_addr(x, y);
        row   = tile_row_addr(tile, y);
        write_byte(row, 8'($urandom));
        write_byte(row + 1'b1, 8'($urandom));
        write_byte(entry, tile);
        render_pixel(x, y);
        write_byte(entry, 8'($urandom));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // Writes and off-screen words may still be in flight.
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_SCROLL_X:         scroll_x_q      = data;
            REG_SCROLL_Y:         scroll_y_q      = data;
            REG_MAP_SELECT:       map_sel_q       = data[0];
            REG_TILE_DATA_SELECT: tile_unsigned_q = data[0];
            REG_BG_PALETTE:       palette_q       = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] sx, input logic [7:0] sy,
                              input logic [7:0] map_sel, input logic [7:0] tile_sel,
                              input logic [7:0] palette);
        write_reg(REG_SCROLL_X, sx);
        write_reg(REG_SCROLL_Y, sy);
        write_reg(REG_MAP_SELECT, map_sel);
        write_reg(REG_TILE_DATA_SELECT, tile_sel);
        write_reg(REG_BG_PALETTE, palette);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            out_hold_cycles--;
        end else if (steady_flow) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected word shade=%0d x=%0d y=%0d",
                                          o_shade, o_out_x, o_out_y));
            end else begin
                expected_pixel = pending_pixels.pop_front();
                if (o_shade !== expected_pixel.shade || o_out_x !== expected_pixel.x ||
                    o_out_y !== expected_pixel.y) begin
                    report_mismatch($sformatf(
                        "expected shade=%0d x=%0d y=%0d, got shade=%0d x=%0d y=%0d",
                        expected_pixel.shade, expected_pixel.x, expected_pixel.y,
                        o_shade, o_out_x, o_out_y));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_config();
        render_pixel(8'd0, 8'd0);
        render_pixel(8'(SCREEN_WIDTH - 1), SCREEN_LINES - 1'b1);
    endtask

    task automatic test_corner_cases();
        logic [7:0] signed_tiles [4];
        signed_tiles = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        write_byte('0, 8'hFF);
        write_byte('1, 8'h00);
        // Off-screen words: no result.
        render_pixel(8'(SCREEN_WIDTH), 8'd0);
        render_pixel(8'hFF, 8'hFF);
        render_pixel(8'd0, SCREEN_LINES);
        render_pixel(8'(SCREEN_WIDTH - 1), 8'hFF);
        set_config(8'hFF, 8'hFF, 8'h01, 8'h01, 8'hE4);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'(SCREEN_WIDTH - 1), SCREEN_LINES - 1'b1);
        // Tile numbers at both ends of the signed and unsigned ranges.
        set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h1B);
        for (int k = 0; k < 4; k++) begin
            write_byte(MAP_LOW_BASE + 13'(k), signed_tiles[k]);
            render_pixel(8'(8 * k), 8'd0);
        end
        write_reg(REG_TILE_DATA_SELECT, 8'h01);
        for (int k = 0; k < 4; k++) render_pixel(8'(8 * k + 7), 8'd7);
        // Indexes past the register list must change nothing.
        for (int k = int'(REG_BG_PALETTE) + 1; k < 2 ** CFG_INDEX_W; k++) begin
            write_reg(CFG_INDEX_W'(k), 8'($urandom));
        end
        render_pixel(8'd0, 8'd0);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        set_config(pick_byte(), pick_byte(), 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (30) begin
            rewrite_and_render(8'($urandom_range(0, SCREEN_WIDTH - 1)),
                               8'($urandom_range(0, SCREEN_LINES - 1)));
        end
        repeat (6) render_run($urandom_range(0, SCREEN_WIDTH - 1),
                              8'($urandom_range(0, SCREEN_LINES - 1)), 16);
        drain_results();
        steady_flow = 1'b0;
    endtask

    task automatic test_output_hold_off();
        @(posedge i_clk);
        out_hold_cycles = HOLD_CYCLES;
        repeat (4) render_run($urandom_range(0, SCREEN_WIDTH - 1),
                              8'($urandom_range(0, SCREEN_LINES - 1)), 12);
        // Sender waits here until every pixel has come back.
        drain_results();
    endtask

    task automatic test_random_traffic();
        int goal;
        int phase;
        int pick;
        goal  = words_sent + RANDOM_WORDS;
        phase = 0;
        while (words_sent < goal) begin
            case (phase)
                0:       set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'($urandom));
                1:       set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: set_config(pick_byte(), pick_byte(), 8'($urandom),
                                    8'($urandom), pick_byte());
            endcase
            repeat (25) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    render_run($urandom_range(0, SCREEN_WIDTH - 1),
                               8'($urandom_range(0, SCREEN_LINES - 1)),
                               $urandom_range(1, 12));
                end else if (pick < 55) begin
                    render_pixel(8'($urandom), 8'($urandom));
                end else if (pick < 65) begin
                    rewrite_and_render(8'($urandom_range(0, SCREEN_WIDTH - 1)),
                                       8'($urandom_range(0, SCREEN_LINES - 1)));
                end else if (pick < 85) begin
                    write_byte(13'($urandom), 8'($urandom));
                end else begin
                    write_byte(MAP_LOW_BASE + 13'($urandom_range(0, MAP_SPAN - 1)),
                               8'($urandom));
                end
            end
            phase++;
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_WRITE;
        i_vram_addr = '0;
        i_vram_data = '0;
        i_pixel_x   = '0;
        i_line_y    = '0;
        i_out_stall = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_corner_cases();
        test_steady_stream();
        test_output_hold_off();
        test_random_traffic();
        drain_results();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
